@@ sv/hsr_pkg.sv @@
// Shared types, constants and romanization tables for the Hangul syllable romanizer.
package hsr_pkg;

   localparam logic [15:0] HANGUL_BASE    = 16'hAC00;
   localparam logic [15:0] HANGUL_LAST    = 16'hD7A3;
   localparam logic [15:0] BYTE_SPAN      = 16'd256;
   localparam logic [4:0]  SILENT_INITIAL = 5'd11;
   localparam logic [4:0]  EMPTY_FINAL    = 5'd0;
   localparam logic [9:0]  FINAL_COUNT    = 10'd28;
   localparam logic [9:0]  MEDIAL_COUNT   = 10'd21;

   // floor(off / 588) == (off * INI_RECIP) >> INI_SHIFT for off < 11172
   localparam logic [14:0] INI_RECIP = 15'd28533;
   localparam int          INI_SHIFT = 24;
   // floor(off / 28) == (off * FIN_RECIP) >> FIN_SHIFT for off < 11172
   localparam logic [14:0] FIN_RECIP = 15'd18725;
   localparam int          FIN_SHIFT = 19;

   localparam int MAX_CHARS = 7;

   typedef enum logic [1:0] {
      CLS_NONE,
      CLS_BYTE,
      CLS_SYLL
   } cls_type;

   // One queued job: a passed-through byte or the three syllable indexes.
   typedef struct packed {
      logic       is_byte;
      logic [7:0] chr;
      logic [4:0] ini;
      logic [4:0] med;
      logic [4:0] fin;
   } entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

   // Romanized part: length and up to three characters, first one in the top byte.
   typedef struct packed {
      logic [1:0]  len;
      logic [23:0] text;
   } part_type;

   localparam part_type PART_EMPTY = '{len: 2'd0, text: 24'd0};

   function automatic part_type part1(logic [7:0] s);
      part1 = '{len: 2'd1, text: {s, 16'd0}};
   endfunction

   function automatic part_type part2(logic [15:0] s);
      part2 = '{len: 2'd2, text: {s, 8'd0}};
   endfunction

   function automatic part_type part3(logic [23:0] s);
      part3 = '{len: 2'd3, text: s};
   endfunction

   function automatic logic [7:0] part_char(part_type p, logic [1:0] i);
      logic [7:0] c;
      case (i)
         2'd0:    c = p.text[23:16];
         2'd1:    c = p.text[15:8];
         2'd2:    c = p.text[7:0];
         default: c = 8'd0;
      endcase
      return c;
   endfunction

   function automatic part_type initial_part(logic [4:0] idx);
      part_type r;
      case (idx)
         5'd0:    r = part1("g");
         5'd1:    r = part2("gg");
         5'd2:    r = part1("n");
         5'd3:    r = part1("d");
         5'd4:    r = part2("dd");
         5'd5:    r = part1("r");
         5'd6:    r = part1("m");
         5'd7:    r = part1("b");
         5'd8:    r = part2("bb");
         5'd9:    r = part1("s");
         5'd10:   r = part2("ss");
         5'd12:   r = part1("j");
         5'd13:   r = part2("jj");
         5'd14:   r = part2("ch");
         5'd15:   r = part1("k");
         5'd16:   r = part1("t");
         5'd17:   r = part1("p");
         5'd18:   r = part1("h");
         default: r = PART_EMPTY;
      endcase
      return r;
   endfunction

   function automatic part_type medial_part(logic [4:0] idx);
      part_type r;
      case (idx)
         5'd0:    r = part1("a");
         5'd1:    r = part2("ae");
         5'd2:    r = part2("ya");
         5'd3:    r = part3("yae");
         5'd4:    r = part2("eo");
         5'd5:    r = part1("e");
         5'd6:    r = part3("yeo");
         5'd7:    r = part2("ye");
         5'd8:    r = part1("o");
         5'd9:    r = part2("wa");
         5'd10:   r = part3("wae");
         5'd11:   r = part2("oe");
         5'd12:   r = part2("yo");
         5'd13:   r = part1("u");
         5'd14:   r = part2("wo");
         5'd15:   r = part2("we");
         5'd16:   r = part2("wi");
         5'd17:   r = part2("yu");
         5'd18:   r = part2("eu");
         5'd19:   r = part2("ui");
         5'd20:   r = part1("i");
         default: r = PART_EMPTY;
      endcase
      return r;
   endfunction

   function automatic part_type final_part(logic [4:0] idx);
      part_type r;
      case (idx)
         5'd1, 5'd2, 5'd3, 5'd24, 5'd27:                  r = part1("k");
         5'd4, 5'd5, 5'd6:                                r = part1("n");
         5'd7, 5'd19, 5'd20, 5'd22, 5'd23, 5'd25:         r = part1("t");
         5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd15:   r = part1("l");
         5'd14, 5'd17, 5'd18, 5'd26:                      r = part1("p");
         5'd16:                                           r = part1("m");
         5'd21:                                           r = part2("ng");
         default:                                         r = PART_EMPTY;
      endcase
      return r;
   endfunction

endpackage

@@ sv/hsr_if.sv @@
// Valid/ready channel interfaces for the request, response and register-write ports.
interface hsr_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        end_of_string;
   modport source (output valid, output code_unit, output end_of_string, input ready);
   modport sink   (input valid, input code_unit, input end_of_string, output ready);
endinterface

interface hsr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_of_run;
   modport source (output valid, output out_char, output last_of_run, input ready);
   modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

interface hsr_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] piece_limit;
   modport source (output valid, output piece_limit, input ready);
   modport sink   (input valid, input piece_limit, output ready);
endinterface

@@ sv/hsr_front.sv @@
// Front end: accept code units, split syllables, apply the piece limit, enqueue jobs.
module hsr_front (
   input  logic                 clock,
   input  logic                 reset,
   hsr_req_if.sink              req_ch,
   input  logic [15:0]          piece_limit,
   input  hsr_pkg::q_status_type q_status,
   output logic                 push,
   output hsr_pkg::entry_type   push_entry
);
   import hsr_pkg::*;

   logic adv;

   // stage 1: raw beat
   logic        s1_valid_ff, s1_valid_in;
   logic [15:0] s1_code_ff;
   logic        s1_eos_ff;

   // stage 2: class, offset and reciprocal products
   logic        s2_valid_ff;
   cls_type     s2_cls_ff, s2_cls_in;
   logic [7:0]  s2_chr_ff;
   logic [13:0] s2_off_ff, s2_off_in;
   logic [4:0]  s2_ini_ff, s2_ini_in;
   logic [9:0]  s2_q28_ff, s2_q28_in;
   logic        s2_eos_ff;
   logic [28:0] prod_ini, prod_q28;

   // stage 3: indexes, limit check
   logic        s3_valid_ff;
   cls_type     s3_cls_ff;
   logic [7:0]  s3_chr_ff;
   logic [4:0]  s3_ini_ff;
   logic [4:0]  s3_med_ff, s3_med_in;
   logic [4:0]  s3_fin_ff, s3_fin_in;
   logic        s3_eos_ff;
   logic [13:0] q28_times;
   logic [9:0]  ini_times;

   logic [16:0] count_ff, count_in;
   logic [1:0]  pieces;
   logic        emit;

   assign adv          = !s3_valid_ff || !q_status.full;
   assign req_ch.ready = adv;
   assign s1_valid_in  = req_ch.valid;

   // classify and start the divisions by 588 and 28
   always_comb begin
      if (s1_code_ff == 16'd0) begin
         s2_cls_in = CLS_NONE;
      end else if (s1_code_ff < BYTE_SPAN) begin
         s2_cls_in = CLS_BYTE;
      end else if (s1_code_ff inside {[HANGUL_BASE:HANGUL_LAST]}) begin
         s2_cls_in = CLS_SYLL;
      end else begin
         s2_cls_in = CLS_NONE;
      end
      s2_off_in = 14'(s1_code_ff - HANGUL_BASE);
      prod_ini  = 29'(s2_off_in) * 29'(INI_RECIP);
      prod_q28  = 29'(s2_off_in) * 29'(FIN_RECIP);
      s2_ini_in = 5'(prod_ini >> INI_SHIFT);
      s2_q28_in = 10'(prod_q28 >> FIN_SHIFT);
   end

   // remainders: final = off - 28*q28, medial = q28 - 21*initial
   always_comb begin
      q28_times = 14'(s2_q28_ff) * 14'(FINAL_COUNT);
      ini_times = 10'(s2_ini_ff) * MEDIAL_COUNT;
      s3_fin_in = 5'(s2_off_ff - q28_times);
      s3_med_in = 5'(s2_q28_ff - ini_times);
   end

   always_comb begin
      pieces = 2'd1 + 2'(s3_ini_ff != SILENT_INITIAL) + 2'(s3_fin_ff != EMPTY_FINAL);
      emit   = s3_valid_ff && (s3_cls_ff != CLS_NONE) && (count_ff < {1'b0, piece_limit});
      push   = emit && adv;
      push_entry.is_byte = (s3_cls_ff == CLS_BYTE);
      push_entry.chr     = s3_chr_ff;
      push_entry.ini     = s3_ini_ff;
      push_entry.med     = s3_med_ff;
      push_entry.fin     = s3_fin_ff;

      count_in = count_ff;
      if (s3_valid_ff && adv) begin
         if (s3_eos_ff) begin
            count_in = 17'd0;
         end else if (emit && (s3_cls_ff == CLS_SYLL)) begin
            count_in = count_ff + 17'(pieces);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         count_ff    <= 17'd0;
      end else begin
         count_ff <= count_in;
         if (adv) begin
            s1_valid_ff <= s1_valid_in;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_code_ff <= req_ch.code_unit;
         s1_eos_ff  <= req_ch.end_of_string;
         s2_cls_ff  <= s2_cls_in;
         s2_chr_ff  <= s1_code_ff[7:0];
         s2_off_ff  <= s2_off_in;
         s2_ini_ff  <= s2_ini_in;
         s2_q28_ff  <= s2_q28_in;
         s2_eos_ff  <= s1_eos_ff;
         s3_cls_ff  <= s2_cls_ff;
         s3_chr_ff  <= s2_chr_ff;
         s3_ini_ff  <= s2_ini_ff;
         s3_med_ff  <= s3_med_in;
         s3_fin_ff  <= s3_fin_in;
         s3_eos_ff  <= s2_eos_ff;
      end
   end

endmodule

@@ sv/hsr_queue.sv @@
// Small job queue between the front end and the character sequencer.
module hsr_queue #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hsr_pkg::entry_type     push_entry,
   input  logic                   pop,
   output hsr_pkg::entry_type     head,
   output hsr_pkg::q_status_type  status,
   output logic [$clog2(DEPTH+1)-1:0] fill
);
   import hsr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   assign status.full      = (cnt_ff == CNT_W'(DEPTH));
   assign status.not_empty = (cnt_ff != '0);
   assign head             = mem_ff[rd_ptr_ff];
   assign fill             = cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ sv/hsr_back.sv @@
// Back end: expand a queued job into characters and send them one beat at a time.
module hsr_back (
   input  logic                  clock,
   input  logic                  reset,
   input  hsr_pkg::entry_type    head,
   input  hsr_pkg::q_status_type q_status,
   output logic                  pop,
   hsr_rsp_if.source             rsp_ch
);
   import hsr_pkg::*;

   logic [7:0] buf_ff [MAX_CHARS];
   logic [7:0] buf_in [MAX_CHARS];
   logic [2:0] cnt_ff, cnt_in;
   logic [7:0] built  [MAX_CHARS];
   logic [2:0] built_len;
   part_type   p_ini, p_med, p_fin;
   logic [2:0] li, lm, lf;
   logic [2:0] pos;
   logic       fire, load;

   // lay the three parts end to end
   always_comb begin
      p_ini = initial_part(head.ini);
      p_med = medial_part(head.med);
      p_fin = final_part(head.fin);
      li    = 3'(p_ini.len);
      lm    = 3'(p_med.len);
      lf    = 3'(p_fin.len);
      pos   = 3'd0;
      for (int k = 0; k < MAX_CHARS; k++) begin
         pos = 3'(k);
         if (head.is_byte) begin
            built[k] = (k == 0) ? head.chr : 8'd0;
         end else if (pos < li) begin
            built[k] = part_char(p_ini, 2'(pos));
         end else if (pos < li + lm) begin
            built[k] = part_char(p_med, 2'(pos - li));
         end else begin
            built[k] = part_char(p_fin, 2'(pos - li - lm));
         end
      end
      built_len = head.is_byte ? 3'd1 : li + lm + lf;
   end

   assign fire = rsp_ch.valid && rsp_ch.ready;
   assign load = (cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && fire);
   assign pop  = load && q_status.not_empty;

   assign rsp_ch.valid       = (cnt_ff != 3'd0);
   assign rsp_ch.out_char    = buf_ff[0];
   assign rsp_ch.last_of_run = (cnt_ff == 3'd1);

   always_comb begin
      cnt_in = cnt_ff;
      for (int k = 0; k < MAX_CHARS; k++) begin
         buf_in[k] = buf_ff[k];
      end
      if (pop) begin
         cnt_in = built_len;
         for (int k = 0; k < MAX_CHARS; k++) begin
            buf_in[k] = built[k];
         end
      end else if (fire) begin
         cnt_in = cnt_ff - 3'd1;
         for (int k = 0; k < MAX_CHARS - 1; k++) begin
            buf_in[k] = buf_ff[k + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_CHARS; k++) begin
         buf_ff[k] <= buf_in[k];
      end
   end

endmodule

@@ sv/hangul_syllable_romanizer.sv @@
// A request beat goes through the front-end stages and the job queue to the output buffer.
// Throughput: the front end takes one code unit per cycle unless the job queue is full; the
//   response sends one character per cycle while ready is high, 1 to 7 per syllable, 1 per byte.
// The output sequencer sets the sustained rate; the job queue absorbs bursts in between.
// Reset (synchronous, active high) empties the pipeline and queue, clears the piece
//   count and sets piece_limit to 65535.
module hangul_syllable_romanizer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   hsr_req_if.sink   req_ch,
   hsr_rsp_if.source rsp_ch,
   hsr_csr_if.sink   csr_ch
);
   import hsr_pkg::*;

   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   logic [15:0]       piece_limit_ff;
   logic [15:0]       piece_limit_in;
   logic              q_push;
   logic              q_pop;
   entry_type         q_push_entry;
   entry_type         q_head;
   q_status_type      q_status;
   logic [FILL_W-1:0] q_fill;

   // Register writes are always taken; hold the limit otherwise.
   assign csr_ch.ready   = 1'b1;
   assign piece_limit_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.piece_limit : piece_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         piece_limit_ff <= 16'hFFFF;
      end else begin
         piece_limit_ff <= piece_limit_in;
      end
   end

   // Front end: classify each beat, split syllables, drop other codes and what is over the limit.
   hsr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .piece_limit (piece_limit_ff),
      .q_status    (q_status),
      .push        (q_push),
      .push_entry  (q_push_entry)
   );

   // Decouple the two sides so either may stall on its own.
   hsr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status),
      .fill       (q_fill)
   );

   // Back end: turn each job into response beats, the last one flagged.
   hsr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .q_status (q_status),
      .pop      (q_pop),
      .rsp_ch   (rsp_ch)
   );

   // Never push into a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_status.full)
      else $error("push into full job queue");

   // Never pop an empty queue.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_status.not_empty)
      else $error("pop from empty job queue");

   // Fill level rises by one after each push that has no pop alongside it.
   assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |=> (q_fill == FILL_W'($past(q_fill) + 1'b1)))
      else $error("queue fill did not advance on push");

   // A fresh reset leaves the limit at its maximum.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (piece_limit_ff == 16'hFFFF || $past(csr_ch.valid)))
      else $error("piece limit not restored by reset");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the Hangul syllable romanizer: directed and random code units.
module tb;
   import hsr_pkg::*;

   localparam int RESET_CYCLES = 12;
   // The pipeline and a short job queue lie ahead of the output; give a dropped item time to leave.
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 3000;
   localparam int INITIAL_SPAN = int'(MEDIAL_COUNT) * int'(FINAL_COUNT);
   localparam int SYLL_RANGE   = int'(HANGUL_LAST - HANGUL_BASE);
   localparam logic [16:0] COUNT_CEIL = 17'h1FFFF;

   // One expected output character and its end-of-run flag.
   typedef struct packed {
      logic [7:0] ch;
      logic       is_last;
   } roman_beat_type;

   logic clock;
   logic reset;

   hsr_req_if req_ch ();
   hsr_rsp_if rsp_ch ();
   hsr_csr_if csr_ch ();

   hangul_syllable_romanizer u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Romanization of each jamo position; an empty string is a silent part.
   string initial_rom [19] = '{
      "g", "gg", "n", "d", "dd", "r", "m", "b", "bb", "s",
      "ss", "", "j", "jj", "ch", "k", "t", "p", "h"
   };
   string medial_rom [21] = '{
      "a", "ae", "ya", "yae", "eo", "e", "yeo", "ye", "o", "wa",
      "wae", "oe", "yo", "u", "wo", "we", "wi", "yu", "eu", "ui", "i"
   };
   string final_rom [28] = '{
      "", "k", "k", "k", "n", "n", "n", "t", "l", "l",
      "l", "l", "l", "l", "p", "l", "m", "p", "p", "t",
      "t", "ng", "t", "t", "k", "t", "p", "k"
   };

   // Predictor state: mirrors the register and the per-string piece count.
   logic [15:0] limit_setting    = 16'hFFFF;
   logic [16:0] pieces_in_string = '0;
   roman_beat_type romanized_q [$];
   roman_beat_type unit_beats [$];

   bit pace_on      = 1'b0;
   bit hold_request = 1'b0;

   int err_count     = 0;
   int units_sent    = 0;
   int chars_checked = 0;
   int units_cut     = 0;
   int limit_writes  = 0;

   // ---------------------------------------------------------------- clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------ predictor
   // Append one character to the beats of the current code unit.
   function automatic void add_unit_beat(logic [7:0] ch);
      roman_beat_type b;
      b.ch      = ch;
      b.is_last = 1'b0;
      unit_beats.insert(unit_beats.size(), b);
   endfunction

   // Append one romanized part; a non-empty part counts as one piece.
   function automatic void emit_part(string part);
      for (int i = 0; i < part.len(); i++)
         add_unit_beat(part[i]);
      if (part.len() != 0 && pieces_in_string != COUNT_CEIL)
         pieces_in_string++;
   endfunction

   // Work out the characters one accepted code unit produces and queue them.
   function automatic void romanize_unit(logic [15:0] code, logic eos);
      int off;
      unit_beats.delete();
      if (code != 16'd0 && pieces_in_string < {1'b0, limit_setting}) begin
         if (code < BYTE_SPAN) begin
            // passed-through byte: one character, no piece
            add_unit_beat(code[7:0]);
         end else if (code >= HANGUL_BASE && code <= HANGUL_LAST) begin
            off = int'(code - HANGUL_BASE);
            emit_part(initial_rom[off / INITIAL_SPAN]);
            emit_part(medial_rom[(off % INITIAL_SPAN) / int'(FINAL_COUNT)]);
            emit_part(final_rom[off % int'(FINAL_COUNT)]);
         end
         // any other code of 256 and above is dropped
      end else if (code != 16'd0) begin
         units_cut++;
      end
      if (unit_beats.size() != 0)
         unit_beats[unit_beats.size() - 1].is_last = 1'b1;
      romanized_q = {romanized_q, unit_beats};
      // end of string clears the count whether or not anything came out
      if (eos)
         pieces_in_string = '0;
   endfunction

   // ------------------------------------------------------------- pacing
   // Mostly no gap, often a short one, now and then a long one.
   function automatic int rand_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // Mostly syllables, then bytes, then zero and arbitrary 16-bit noise.
   function automatic logic [15:0] rand_unit();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return HANGUL_BASE + 16'($urandom_range(0, SYLL_RANGE));
      else if (r < 85)
         return 16'($urandom_range(1, 255));
      else if (r < 88)
         return 16'h0000;
      else
         return 16'($urandom());
   endfunction

   // -------------------------------------------------------------- driver
   // Offer one code unit and predict its output on acceptance. Valid stays high on
   // return so back-to-back beats need no second assignment in one step.
   task automatic send_unit(logic [15:0] code, logic eos);
      int gap;
      gap = pace_on ? rand_gap() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.code_unit     <= code;
      req_ch.end_of_string <= eos;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      units_sent++;
      romanize_unit(code, eos);
   endtask

   // Drop valid, wait for every expected character, then let dropped items clear.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (romanized_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write piece_limit; only called once the block has settled.
   task automatic write_limit(logic [15:0] value);
      csr_ch.valid       <= 1'b1;
      csr_ch.piece_limit <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      limit_setting = value;
      limit_writes++;
   endtask

   // ------------------------------------------------------------ receiver
   // Drive rsp ready: random stalls while pacing is on, one long hold on request.
   initial begin : rsp_pacing
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            gap = HOLD_CYCLES;
         end else begin
            gap = pace_on ? rand_gap() : 0;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // ------------------------------------------------------------- checker
   // Compare each accepted character beat with the oldest expectation.
   always @(posedge clock) begin : check_beats
      roman_beat_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (romanized_q.size() == 0) begin
            $error("out_char: expected nothing, got 0x%02h", rsp_ch.out_char);
            err_count++;
         end else begin
            want = romanized_q.pop_front();
            chars_checked++;
            if (rsp_ch.out_char !== want.ch) begin
               $error("out_char: expected 0x%02h, got 0x%02h", want.ch, rsp_ch.out_char);
               err_count++;
            end
            if (rsp_ch.last_of_run !== want.is_last) begin
               $error("last_of_run: expected %0b, got %0b", want.is_last,
                      rsp_ch.last_of_run);
               err_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------ watchdog
   // End the run when no beat moves on any channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
             (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb: done, errors");
      $finish;
   end

   // --------------------------------------------------------------- tests
   // Bytes at both ends, zero, dropped codes on both sides of the syllable block,
   // the first and last syllables, silent parts and the longest syllable.
   task automatic test_special_codes();
      logic [15:0] codes [] = '{
         16'h0001, 16'h0041, 16'h00FF, 16'h0000, 16'h0100, 16'hABFF,
         16'hD7A4, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h8000,
         HANGUL_BASE,   // ga
         16'hAC01,      // gak
         16'hAEB5,      // ggyaeng, seven characters
         16'hC544,      // silent initial, empty final
         16'hC774,      // silent initial with i
         HANGUL_LAST    // hik
      };
      pace_on = 1'b1;
      foreach (codes[i])
         send_unit(codes[i], i == codes.size() - 1);
      // zero and dropped codes as the end of a string
      send_unit(HANGUL_BASE, 1'b0);
      send_unit(16'h0000, 1'b1);
      send_unit(16'hF000, 1'b1);
   endtask

   // Limit at zero, one, two and the maximum: crossing, cut-off and reset on end.
   task automatic test_piece_limit();
      pace_on = 1'b1;
      settle();
      write_limit(16'h0000);
      send_unit(HANGUL_BASE, 1'b0);
      send_unit(16'h0041, 1'b0);
      send_unit(16'hAC01, 1'b1);

      settle();
      write_limit(16'h0001);
      send_unit(16'hAEB5, 1'b0);   // starts under the limit, sent in full
      send_unit(HANGUL_BASE, 1'b0);
      send_unit(16'h0041, 1'b0);
      send_unit(16'h0000, 1'b1);
      send_unit(HANGUL_BASE, 1'b1);

      settle();
      write_limit(16'h0002);
      send_unit(16'h0041, 1'b0);
      send_unit(16'h0042, 1'b0);
      send_unit(16'hC544, 1'b0);
      send_unit(16'hC774, 1'b0);
      send_unit(HANGUL_BASE, 1'b1);

      settle();
      write_limit(16'hFFFF);
   endtask

   // Hold the receiver off while the sender keeps offering, so the input stalls.
   task automatic test_output_stall();
      settle();
      pace_on      = 1'b0;
      hold_request = 1'b1;
      for (int k = 0; k < 24; k++)
         send_unit(HANGUL_BASE + 16'($urandom_range(0, SYLL_RANGE)), k == 23);
   endtask

   // Random strings under a series of limits, one phase with no idling.
   task automatic test_random_strings();
      logic [15:0] lim;
      int sent;
      int len;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       lim = 16'hFFFF;
            1:       lim = 16'($urandom_range(1, 6));
            2:       lim = 16'($urandom());
            3:       lim = 16'h0001;
            4:       lim = 16'($urandom_range(2, 12));
            default: lim = 16'h0000;
         endcase
         settle();
         write_limit(lim);
         pace_on = (phase != 2);
         sent = 0;
         while (sent < (phase == 5 ? 20 : 56)) begin
            len = $urandom_range(1, 10);
            // most strings close with an end marker, some run into the next
            for (int k = 0; k < len; k++)
               send_unit(rand_unit(), k == len - 1 && $urandom_range(0, 9) != 0);
            sent += len;
         end
      end
   endtask

   // ---------------------------------------------------------------- main
   initial begin : main_seq
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.code_unit     <= 16'd0;
      req_ch.end_of_string <= 1'b0;
      csr_ch.valid         <= 1'b0;
      csr_ch.piece_limit   <= 16'd0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_special_codes();
      test_piece_limit();
      test_output_stall();
      test_random_strings();
      settle();

      $display("tb: %0d code units sent, %0d characters checked, %0d limit settings",
               units_sent, chars_checked, limit_writes);
      $display("tb: %0d units ignored at the piece limit, one %0d-cycle output hold",
               units_cut, HOLD_CYCLES);
      if (err_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
